/* src/bcdr_pkg.sv */
// ----------------------------------------------------------------------------
// bcdr_pkg
// Shared types and constants for the button debounce, menu combo and
// auto-repeat block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcdr_pkg;

  localparam int unsigned BtnW  = 8;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned DirW  = 4;

  // button bit positions
  localparam int unsigned BitRight  = 0;
  localparam int unsigned BitLeft   = 1;
  localparam int unsigned BitUp     = 2;
  localparam int unsigned BitDown   = 3;
  localparam int unsigned BitSelect = 6;
  localparam int unsigned BitStart  = 7;

  localparam logic [BtnW-1:0] DpadMask = 8'h0F;
  localparam logic [BtnW-1:0] PairMask = 8'hC0;

  localparam logic [DirW-1:0] DirNone  = 4'b0000;
  localparam logic [DirW-1:0] DirRight = 4'b0001;
  localparam logic [DirW-1:0] DirLeft  = 4'b0010;
  localparam logic [DirW-1:0] DirUp    = 4'b0100;
  localparam logic [DirW-1:0] DirDown  = 4'b1000;

  localparam logic [CfgW-1:0] DebounceRst    = 16'd20;
  localparam logic [CfgW-1:0] RepeatDelayRst = 16'd400;
  localparam logic [CfgW-1:0] RepeatRst      = 16'd100;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_MENU   = 3'd1,
    EV_VOL_UP = 3'd2,
    EV_VOL_DN = 3'd3,
    EV_BRI_UP = 3'd4,
    EV_BRI_DN = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_REPEAT_DELAY = 2'd1,
    CFG_REPEAT       = 2'd2
  } cfg_idx_e;

  function automatic event_e code_of_dir(input logic [DirW-1:0] dir);
    event_e code;
    code = EV_NONE;
    if (dir == DirUp) code = EV_VOL_UP;
    else if (dir == DirDown) code = EV_VOL_DN;
    else if (dir == DirRight) code = EV_BRI_UP;
    else if (dir == DirLeft) code = EV_BRI_DN;
    return code;
  endfunction

endpackage

`default_nettype wire

/* src/button_combo_debounce_repeat.sv */
// ----------------------------------------------------------------------------
// button_combo_debounce_repeat
// Debounces a raw button word, fires a menu event on Start+Select and
// auto-repeating adjust events on Select+direction.
// ----------------------------------------------------------------------------
// Every accepted sample gives exactly one result in the next cycle; a new sample
// is taken every cycle unless a result waits. The whole step (settle compare,
// menu latch, repeat deadline compare and add) runs in one pass between the
// input handshake and the output register. A sample is taken in the same cycle
// as the previous result is taken; while that result waits, in_ready_o stays
// low. Configuration writes are taken at once (cfg_ready_o is always high);
// indexes beyond repeat_ms are ignored.
`timescale 1ns / 1ps
`default_nettype none

module button_combo_debounce_repeat (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bcdr_pkg::BtnW-1:0]     raw_buttons_i,
  input  wire logic [bcdr_pkg::TimeW-1:0]    time_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         event_code_o,
  output logic [bcdr_pkg::BtnW-1:0]          joypad_byte_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [bcdr_pkg::CfgW-1:0]     cfg_data_i
);

  logic [bcdr_pkg::CfgW-1:0]  debounce_q, repeat_delay_q, repeat_q;
  logic [bcdr_pkg::BtnW-1:0]  last_raw_q, last_raw_d;
  logic [bcdr_pkg::BtnW-1:0]  stable_q, stable_d;
  logic [bcdr_pkg::TimeW-1:0] change_time_q, change_time_d;
  logic [bcdr_pkg::TimeW-1:0] deadline_q, deadline_d;
  logic [bcdr_pkg::DirW-1:0]  held_dir_q, held_dir_d;
  logic                       menu_q, menu_d;

  logic                       out_valid_q;
  bcdr_pkg::event_e           event_q, event_d;
  logic [bcdr_pkg::BtnW-1:0]  pad_q, pad_d;

  logic                       in_xfer;
  logic [bcdr_pkg::TimeW-1:0] settle_elapsed;
  logic [bcdr_pkg::TimeW-1:0] repeat_diff;
  logic [bcdr_pkg::DirW-1:0]  dpad;
  logic                       pair_held;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign settle_elapsed = time_ms_i - change_time_q;
  assign repeat_diff    = time_ms_i - deadline_q;

  always_comb begin
    last_raw_d    = last_raw_q;
    stable_d      = stable_q;
    change_time_d = change_time_q;
    deadline_d    = deadline_q;
    held_dir_d    = held_dir_q;
    menu_d        = menu_q;
    event_d       = bcdr_pkg::EV_NONE;

    // settle
    if (raw_buttons_i != last_raw_q) begin
      last_raw_d    = raw_buttons_i;
      change_time_d = time_ms_i;
    end else if (last_raw_q != stable_q &&
                 settle_elapsed >= {{(bcdr_pkg::TimeW-bcdr_pkg::CfgW){1'b0}}, debounce_q}) begin
      stable_d = last_raw_q;
    end

    dpad      = stable_d[bcdr_pkg::DirW-1:0];
    pair_held = (stable_d & bcdr_pkg::PairMask) == bcdr_pkg::PairMask;

    // menu combo
    if (!pair_held) begin
      menu_d = 1'b0;
    end else if (!menu_q) begin
      menu_d  = 1'b1;
      event_d = bcdr_pkg::EV_MENU;
    end

    // select + direction adjust
    if (event_d == bcdr_pkg::EV_NONE) begin
      if (!stable_d[bcdr_pkg::BitSelect] || dpad == bcdr_pkg::DirNone) begin
        held_dir_d = bcdr_pkg::DirNone;
      end else if (held_dir_q != bcdr_pkg::DirNone &&
                   (dpad & held_dir_q) != bcdr_pkg::DirNone) begin
        if (!repeat_diff[bcdr_pkg::TimeW-1]) begin
          deadline_d = time_ms_i +
                       {{(bcdr_pkg::TimeW-bcdr_pkg::CfgW){1'b0}}, repeat_q};
          event_d    = bcdr_pkg::code_of_dir(held_dir_q);
        end
      end else begin
        if (dpad[bcdr_pkg::BitUp]) held_dir_d = bcdr_pkg::DirUp;
        else if (dpad[bcdr_pkg::BitDown]) held_dir_d = bcdr_pkg::DirDown;
        else if (dpad[bcdr_pkg::BitLeft]) held_dir_d = bcdr_pkg::DirLeft;
        else held_dir_d = bcdr_pkg::DirRight;
        deadline_d = time_ms_i +
                     {{(bcdr_pkg::TimeW-bcdr_pkg::CfgW){1'b0}}, repeat_delay_q};
        event_d    = bcdr_pkg::code_of_dir(held_dir_d);
      end
    end

    // joypad masking
    pad_d = stable_d;
    if (stable_d[bcdr_pkg::BitSelect]) pad_d = pad_d & ~bcdr_pkg::DpadMask;
    if (menu_d) pad_d = pad_d & ~bcdr_pkg::PairMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= bcdr_pkg::DebounceRst;
      repeat_delay_q <= bcdr_pkg::RepeatDelayRst;
      repeat_q       <= bcdr_pkg::RepeatRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bcdr_pkg::CFG_DEBOUNCE:     debounce_q     <= cfg_data_i;
        bcdr_pkg::CFG_REPEAT_DELAY: repeat_delay_q <= cfg_data_i;
        bcdr_pkg::CFG_REPEAT:       repeat_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= '0;
      stable_q      <= '0;
      change_time_q <= '0;
      deadline_q    <= '0;
      held_dir_q    <= bcdr_pkg::DirNone;
      menu_q        <= 1'b0;
    end else if (in_xfer) begin
      last_raw_q    <= last_raw_d;
      stable_q      <= stable_d;
      change_time_q <= change_time_d;
      deadline_q    <= deadline_d;
      held_dir_q    <= held_dir_d;
      menu_q        <= menu_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      event_q <= event_d;
      pad_q   <= pad_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_code_o  = event_q;
  assign joypad_byte_o = pad_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce, menu combo and auto-repeat
// block: samples go in over valid/ready with random gaps, a predictor keeps
// its own debounce, latch and repeat state, and every result is matched in
// order against the oldest expected event code and joypad byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] CfgSpare = 2'd3;

  typedef struct packed {
    bcdr_pkg::event_e                code;
    logic [bcdr_pkg::BtnW-1:0]       pad;
  } pad_event_t;

  class button_event_predictor;
    logic [bcdr_pkg::CfgW-1:0]  debounce_ms, repeat_delay_ms, repeat_ms;
    logic [bcdr_pkg::BtnW-1:0]  last_raw, stable;
    logic [bcdr_pkg::TimeW-1:0] change_t, deadline;
    logic [bcdr_pkg::DirW-1:0]  held_dir;
    bit                         menu_on;
    pad_event_t                 expected_events[$];
    int                         mismatches;

    function new();
      debounce_ms     = 16'd20;
      repeat_delay_ms = 16'd400;
      repeat_ms       = 16'd100;
      last_raw        = '0;
      stable          = '0;
      change_t        = '0;
      deadline        = '0;
      held_dir        = bcdr_pkg::DirNone;
      menu_on         = 1'b0;
      mismatches      = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void write_reg(logic [1:0] idx, logic [bcdr_pkg::CfgW-1:0] data);
      case (idx)
        bcdr_pkg::CFG_DEBOUNCE:     debounce_ms = data;
        bcdr_pkg::CFG_REPEAT_DELAY: repeat_delay_ms = data;
        bcdr_pkg::CFG_REPEAT:       repeat_ms = data;
        default: ;
      endcase
    endfunction

    function bcdr_pkg::event_e dir_event(logic [bcdr_pkg::DirW-1:0] dir);
      case (dir)
        bcdr_pkg::DirUp:    return bcdr_pkg::EV_VOL_UP;
        bcdr_pkg::DirDown:  return bcdr_pkg::EV_VOL_DN;
        bcdr_pkg::DirRight: return bcdr_pkg::EV_BRI_UP;
        bcdr_pkg::DirLeft:  return bcdr_pkg::EV_BRI_DN;
        default:            return bcdr_pkg::EV_NONE;
      endcase
    endfunction

    function void take_sample(logic [bcdr_pkg::BtnW-1:0] raw,
                              logic [bcdr_pkg::TimeW-1:0] now);
      pad_event_t                 res;
      logic [bcdr_pkg::TimeW-1:0] gap;
      logic [bcdr_pkg::DirW-1:0]  dpad;
      // settle timer
      if (raw != last_raw) begin
        last_raw = raw;
        change_t = now;
      end else if (last_raw != stable) begin
        gap = now - change_t;
        if (gap >= {16'd0, debounce_ms}) stable = last_raw;
      end
      // start+select latch
      res.code = bcdr_pkg::EV_NONE;
      if ((stable & bcdr_pkg::PairMask) != bcdr_pkg::PairMask) begin
        menu_on = 1'b0;
      end else if (!menu_on) begin
        menu_on  = 1'b1;
        res.code = bcdr_pkg::EV_MENU;
      end
      // select+direction adjust
      if (res.code == bcdr_pkg::EV_NONE) begin
        dpad = stable[bcdr_pkg::DirW-1:0];
        if (!stable[bcdr_pkg::BitSelect] || dpad == '0) begin
          held_dir = bcdr_pkg::DirNone;
        end else if (held_dir != bcdr_pkg::DirNone && (dpad & held_dir) != '0) begin
          gap = now - deadline;
          if (!gap[bcdr_pkg::TimeW-1]) begin
            deadline = now + {16'd0, repeat_ms};
            res.code = dir_event(held_dir);
          end
        end else begin
          if ((dpad & bcdr_pkg::DirUp) != '0) held_dir = bcdr_pkg::DirUp;
          else if ((dpad & bcdr_pkg::DirDown) != '0) held_dir = bcdr_pkg::DirDown;
          else if ((dpad & bcdr_pkg::DirLeft) != '0) held_dir = bcdr_pkg::DirLeft;
          else held_dir = bcdr_pkg::DirRight;
          deadline = now + {16'd0, repeat_delay_ms};
          res.code = dir_event(held_dir);
        end
      end
      res.pad = stable;
      if (res.pad[bcdr_pkg::BitSelect]) res.pad = res.pad & ~bcdr_pkg::DpadMask;
      if (menu_on) res.pad = res.pad & ~bcdr_pkg::PairMask;
      expected_events.push_back(res);
    endfunction

    task match_result(logic [2:0] code, logic [bcdr_pkg::BtnW-1:0] pad);
      pad_event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("result code %0d pad %h with nothing expected", code, pad));
      end else begin
        want = expected_events.pop_front();
        if (code !== want.code)
          report($sformatf("event_code %0d, expected %0d", code, want.code));
        if (pad !== want.pad)
          report($sformatf("joypad_byte %h, expected %h", pad, want.pad));
      end
    endtask

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready_o;
  logic [bcdr_pkg::BtnW-1:0]  raw_buttons = '0;
  logic [bcdr_pkg::TimeW-1:0] time_ms = '0;
  logic                       out_valid_o;
  logic                       out_ready = 1'b1;
  logic [2:0]                 event_code_o;
  logic [bcdr_pkg::BtnW-1:0]  joypad_byte_o;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready_o;
  logic [1:0]                 cfg_index = '0;
  logic [bcdr_pkg::CfgW-1:0]  cfg_data = '0;

  button_event_predictor      predictor;
  bit                         quiet = 1'b0;
  int                         stall_pct = 15;
  int                         stall_left = 0;
  logic [bcdr_pkg::TimeW-1:0] cur_time = '0;

  button_combo_debounce_repeat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .raw_buttons_i (raw_buttons),
    .time_ms_i     (time_ms),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .event_code_o  (event_code_o),
    .joypad_byte_o (joypad_byte_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 3);
    if (!quiet && stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) predictor.match_result(event_code_o, joypad_byte_o);
      if (in_valid && in_ready_o) predictor.take_sample(raw_buttons, time_ms);
      if (cfg_valid && cfg_ready_o) predictor.write_reg(cfg_index, cfg_data);
    end
  end

  task send_sample(logic [bcdr_pkg::BtnW-1:0] raw, logic [bcdr_pkg::TimeW-1:0] t,
                   int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid    <= 1'b1;
    raw_buttons <= raw;
    time_ms     <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task drain();
    int k;
    @(negedge clk_i);
    in_valid <= 1'b0;
    for (k = 0; k < 5000 && predictor.pending() != 0; k++) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [bcdr_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task program_regs(logic [bcdr_pkg::CfgW-1:0] dbn, logic [bcdr_pkg::CfgW-1:0] rdly,
                    logic [bcdr_pkg::CfgW-1:0] rpt);
    drain();
    write_reg(bcdr_pkg::CFG_DEBOUNCE, dbn);
    write_reg(bcdr_pkg::CFG_REPEAT_DELAY, rdly);
    write_reg(bcdr_pkg::CFG_REPEAT, rpt);
    write_reg(CfgSpare, 16'($urandom()));
  endtask

  // held words with bounce and time jumps, mostly select+dpad and start+select
  task run_random(int count, int idle_pct);
    int                        sent, hold, k, scale, r;
    logic [bcdr_pkg::BtnW-1:0] word, prev;
    sent = 0;
    prev = '0;
    scale = predictor.debounce_ms;
    if (predictor.repeat_delay_ms > scale) scale = predictor.repeat_delay_ms;
    if (predictor.repeat_ms > scale) scale = predictor.repeat_ms;
    scale = scale / 3 + 4;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        word = 8'(8'h40 | ($urandom() & 8'hB0) | $urandom_range(1, 15));
      end else if (r < 50) begin
        word = (prev | 8'h40) ^ (8'h01 << $urandom_range(0, 3));
      end else if (r < 65) begin
        word = 8'(8'hC0 | $urandom_range(0, 63));
      end else begin
        word = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 5) cur_time = $urandom();
      hold = $urandom_range(2, 12);
      for (k = 0; k < hold && sent < count; k++) begin
        cur_time = cur_time + $urandom_range(0, scale);
        if ($urandom_range(0, 99) < 8) send_sample(8'($urandom_range(0, 255)), cur_time, idle_pct);
        else send_sample(word, cur_time, idle_pct);
        sent++;
      end
      prev = word;
    end
  endtask

  initial begin
    predictor = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // reset settings: menu latch, repeat timing, sticky direction, time wrap
    send_sample(8'h00, 32'd0, 0);
    send_sample(8'hC0, 32'd10, 0);
    send_sample(8'hC0, 32'd30, 0);
    send_sample(8'hC0, 32'd40, 0);
    send_sample(8'h44, 32'd50, 0);
    send_sample(8'h44, 32'd69, 0);
    send_sample(8'h44, 32'd70, 0);
    send_sample(8'h44, 32'd469, 0);
    send_sample(8'h44, 32'd470, 0);
    send_sample(8'h4F, 32'd480, 0);
    send_sample(8'h4F, 32'd500, 0);
    send_sample(8'h4B, 32'd510, 0);
    send_sample(8'h4B, 32'd530, 0);
    send_sample(8'hFF, 32'd540, 0);
    send_sample(8'hFF, 32'd560, 0);
    send_sample(8'hFF, 32'd1000, 0);
    send_sample(8'h3F, 32'd1010, 0);
    send_sample(8'h3F, 32'd1030, 0);
    send_sample(8'h41, 32'hFFFF_FFF0, 0);
    send_sample(8'h41, 32'h0000_0004, 0);
    send_sample(8'h42, 32'h0000_0010, 0);
    send_sample(8'h42, 32'h0000_0030, 0);
    send_sample(8'h55, 32'hFFFF_FFFF, 0);
    send_sample(8'h55, 32'h8000_0000, 0);
    send_sample(8'hAA, 32'h7FFF_FFFF, 0);

    program_regs(16'd20, 16'd400, 16'd100);
    run_random(150, 20);

    program_regs(16'd0, 16'd0, 16'd0);
    send_sample(8'h48, cur_time, 0);
    send_sample(8'h48, cur_time, 0);
    send_sample(8'h48, cur_time, 0);
    run_random(150, 15);

    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    cur_time = 32'hFFFE_0000;
    run_random(120, 15);

    stall_pct = 0;
    program_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                 16'($urandom_range(0, 200)));
    run_random(180, 0);

    stall_pct = 20;
    program_regs(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 3000)));
    run_random(80, 25);

    quiet = 1'b1;
    run_random(70, 0);

    drain();
    if (predictor.pending() != 0)
      predictor.report($sformatf("%0d results never arrived", predictor.pending()));
    if (predictor.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
